@@ src/crsf_pkg.sv @@
// Shared types, constants and CRC function for the CRSF RC frame deframer.
package crsf_pkg;

  localparam int BODY_DEPTH_DEFAULT = 64;

  localparam logic [7:0] ADDR_FC      = 8'hC8;
  localparam logic [7:0] ADDR_RX      = 8'hEC;
  localparam logic [7:0] ADDR_TX      = 8'hEA;
  localparam logic [7:0] RC_TYPE      = 8'h16;
  localparam logic [5:0] RC_LENGTH    = 6'd24;
  localparam logic [7:0] LEN_MIN      = 8'd2;
  localparam logic [7:0] LEN_MAX      = 8'd62;
  localparam logic [7:0] CRC_POLY     = 8'hD5;
  localparam logic [4:0] LAST_INDEX   = 5'd21;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic        bank;
    logic [31:0] total;
  } job_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/crsf_body_ram.sv @@
// Two-bank body byte memory: one write port, one registered read port.
module crsf_body_ram #(
  parameter int BODY_DEPTH = crsf_pkg::BODY_DEPTH_DEFAULT,
  localparam int AW = $clog2(BODY_DEPTH) + 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/crsf_front.sv @@
// Front end: hunts for frames, checks length and CRC, stores the body, posts jobs.
module crsf_front #(
  parameter int BODY_DEPTH = crsf_pkg::BODY_DEPTH_DEFAULT,
  localparam int AW = $clog2(BODY_DEPTH) + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          rx_byte,
  output logic                job_push,
  output crsf_pkg::job_t      job,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data
);

  crsf_pkg::phase_t phase, phase_next;
  logic [5:0]  body_length;
  logic [5:0]  body_count;
  logic [7:0]  running_crc;
  logic [7:0]  crc_next;
  logic        type_ok;
  logic        wr_bank;
  logic [31:0] frame_count;
  logic [31:0] frame_count_next;
  logic        is_final;
  logic        frame_good;
  logic        is_addr;
  logic        len_ok;

  always_comb begin
    crc_next         = crsf_pkg::crc8_update(running_crc, rx_byte);
    is_final         = ({1'b0, body_count} + 7'd1) >= {1'b0, body_length};
    is_addr          = (rx_byte == crsf_pkg::ADDR_FC) || (rx_byte == crsf_pkg::ADDR_RX) ||
                       (rx_byte == crsf_pkg::ADDR_TX);
    len_ok           = (rx_byte >= crsf_pkg::LEN_MIN) && (rx_byte <= crsf_pkg::LEN_MAX);
    frame_good       = (rx_byte == running_crc) && type_ok &&
                       (body_length == crsf_pkg::RC_LENGTH);
    frame_count_next = frame_count + 32'd1;
    phase_next       = phase;
    unique case (phase)
      crsf_pkg::PH_HUNT: phase_next = is_addr ? crsf_pkg::PH_LEN : crsf_pkg::PH_HUNT;
      crsf_pkg::PH_LEN:  phase_next = len_ok ? crsf_pkg::PH_BODY : crsf_pkg::PH_HUNT;
      crsf_pkg::PH_BODY: phase_next = is_final ? crsf_pkg::PH_HUNT : crsf_pkg::PH_BODY;
      default:           phase_next = is_addr ? crsf_pkg::PH_LEN : crsf_pkg::PH_HUNT;
    endcase
  end

  assign job_push   = in_valid && (phase == crsf_pkg::PH_BODY) && is_final && frame_good;
  assign job.bank   = wr_bank;
  assign job.total  = frame_count_next;
  assign wr_en      = in_valid && (phase == crsf_pkg::PH_BODY) &&
                      (32'(body_count) < BODY_DEPTH);
  assign wr_addr    = {wr_bank, (AW-1)'(body_count)};
  assign wr_data    = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= crsf_pkg::PH_HUNT;
      body_length <= '0;
      body_count  <= '0;
      running_crc <= '0;
      type_ok     <= 1'b0;
      wr_bank     <= 1'b0;
      frame_count <= '0;
    end else if (in_valid) begin
      phase <= phase_next;
      if (phase == crsf_pkg::PH_LEN && len_ok) begin
        body_length <= rx_byte[5:0];
        body_count  <= '0;
        running_crc <= '0;
      end
      if (phase == crsf_pkg::PH_BODY && !is_final) begin
        running_crc <= crc_next;
        body_count  <= body_count + 6'd1;
        if (body_count == 6'd0) begin
          type_ok <= (rx_byte == crsf_pkg::RC_TYPE);
        end
      end
      if (job_push) begin
        frame_count <= frame_count_next;
        wr_bank     <= ~wr_bank;
      end
    end
  end

endmodule

@@ src/crsf_jobq.sv @@
// Two-entry job queue between the front end and the payload emitter.
module crsf_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  crsf_pkg::job_t push_job,
  input  logic           pop,
  output crsf_pkg::job_t head,
  output logic           nonempty,
  output logic [1:0]     count
);

  crsf_pkg::job_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;

  assign head     = slot[rd_ptr];
  assign nonempty = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ src/crsf_back.sv @@
// Back end: reads the stored payload of each job and presents it byte by byte.
module crsf_back #(
  parameter int BODY_DEPTH = crsf_pkg::BODY_DEPTH_DEFAULT,
  localparam int AW = $clog2(BODY_DEPTH) + 1
) (
  input  logic           clk,
  input  logic           rst,
  input  crsf_pkg::job_t head,
  input  logic           head_valid,
  output logic           head_pop,
  output logic           active,
  output logic           rd_en,
  output logic [AW-1:0]  rd_addr,
  input  logic [7:0]     rd_data,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     payload_byte,
  output logic [4:0]     byte_index,
  output logic           last,
  output logic [31:0]    frame_total
);

  crsf_pkg::job_t cur;
  logic [4:0]     idx;
  logic           rd_pend;
  logic [4:0]     pend_idx;
  logic [31:0]    pend_total;
  logic           out_valid;
  logic           load_out;

  assign empty    = !out_valid;
  assign load_out = rd_pend && (!out_valid || pop);
  assign rd_en    = active && (!rd_pend || load_out);
  assign rd_addr  = {cur.bank, (AW-1)'(idx) + (AW-1)'(1)};
  assign head_pop = !active && head_valid;

  always_ff @(posedge clk) begin
    if (head_pop) begin
      cur <= head;
    end
    if (rd_en) begin
      pend_idx   <= idx;
      pend_total <= cur.total;
    end
    if (load_out) begin
      payload_byte <= rd_data;
      byte_index   <= pend_idx;
      last         <= (pend_idx == crsf_pkg::LAST_INDEX);
      frame_total  <= pend_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (head_pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (rd_en) begin
        if (idx == crsf_pkg::LAST_INDEX) begin
          active <= 1'b0;
        end else begin
          idx <= idx + 5'd1;
        end
      end
      if (rd_en) begin
        rd_pend <= 1'b1;
      end else if (load_out) begin
        rd_pend <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/crsf_rc_frame_deframer_unit.sv @@
// Top level of the CRSF RC frame deframer: front end, job queue, body memory, back end.
// Input: one byte per cycle while full is low; full rises while two valid frames are pending.
// Output: valid frames are queued, read from body memory and registered out, then one
//   byte per cycle while pop is held; 22 bytes per frame, paced by the body memory read port.
// Reset: synchronous rst clears parser, queue, emitter and frame count; body memory keeps
//   its contents and needs no clearing pass.
module crsf_rc_frame_deframer_unit #(
  parameter int BODY_DEPTH = crsf_pkg::BODY_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  payload_byte,
  output logic [4:0]  byte_index,
  output logic        last,
  output logic [31:0] frame_total
);

  localparam int AW = $clog2(BODY_DEPTH) + 1;

  logic           in_valid;
  logic           job_push;
  crsf_pkg::job_t job;
  crsf_pkg::job_t head;
  logic           head_valid;
  logic           head_pop;
  logic [1:0]     q_count;
  logic           active;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;

  assign full     = ({1'b0, q_count} + {2'b00, active}) >= 3'd2;
  assign in_valid = push && !full;

  crsf_front #(.BODY_DEPTH(BODY_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .rx_byte  (rx_byte),
    .job_push (job_push),
    .job      (job),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  crsf_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (head_pop),
    .head     (head),
    .nonempty (head_valid),
    .count    (q_count)
  );

  crsf_body_ram #(.BODY_DEPTH(BODY_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  crsf_back #(.BODY_DEPTH(BODY_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .head_pop     (head_pop),
    .active       (active),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .pop          (pop),
    .empty        (empty),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last         (last),
    .frame_total  (frame_total)
  );

endmodule
